// ===== hw/rtl/prr_pkg.sv =====
// ----------------------------------------------------------------------------
// Packet retransmit responder package
// Field widths, request codes and fixed constants shared by the block.
// ----------------------------------------------------------------------------
package prr_pkg;

    localparam int unsigned LEN_W    = 7;
    localparam int unsigned PIDX_W   = 3;
    localparam int unsigned ID_W     = 7;
    localparam int unsigned PAY_W    = 64;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LIMIT_W  = 4;
    localparam int unsigned PADDR_W  = 3;
    localparam int unsigned PDATA_W  = 32;

    typedef enum logic [1:0] {
        REQ_APPEND = 2'd0,
        REQ_FLUSH  = 2'd1,
        REQ_HOST   = 2'd2,
        REQ_UNUSED = 2'd3
    } t_req;

    // Register index, taken from bit 2 of the byte address.
    localparam logic REG_LIMIT = 1'b0;

    localparam logic [ID_W-1:0]    ID_MODULUS  = 7'd100;
    localparam logic [ID_W-1:0]    ID_RESET    = 7'd1;
    localparam logic [BYTE_W-1:0]  ALL_PACKETS = 8'hFF;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd5;

endpackage

// ===== hw/rtl/prr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module prr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

// ===== hw/rtl/packet_retransmit_responder.sv =====
// ----------------------------------------------------------------------------
// Packet retransmit responder
// Collects message bytes, publishes them on a flush and answers host
// requests with the selected packets of the published message.
// ----------------------------------------------------------------------------
// A host request is accepted, then every packet slot that is skipped is
// passed over in turn, and every packet sent is selected, has its bytes read
// and waits on the output register until it is taken. Packet bytes come from
// the single read port of the buffer RAM, which delivers one byte a cycle. A
// request that sees no message data is answered with a single acknowledgement
// word, ready on the cycle after the request. The write and send buffers are
// the two halves of one RAM and a flush swaps the halves, so a flush costs no
// copy. The RAM needs no clearing pass after reset; input stays stalled while
// a request is served.
module packet_retransmit_responder import prr_pkg::*; #(
    parameter int unsigned PAYLOAD_BYTES = 8,
    parameter int unsigned MAX_PACKETS   = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_req_type,
    input  logic [BYTE_W-1:0]    i_data_byte,
    input  logic [BYTE_W-1:0]    i_requested_bits,
    input  logic [BYTE_W-1:0]    i_requested_id,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [LEN_W-1:0]     o_buffer_length,
    output logic [PIDX_W-1:0]    o_packet_index,
    output logic [ID_W-1:0]      o_message_id,
    output logic [PAY_W-1:0]     o_payload,
    output logic                 o_is_ack,
    output logic                 o_last,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    localparam int unsigned SIZE  = PAYLOAD_BYTES * MAX_PACKETS;
    localparam int unsigned AW    = (SIZE > 1) ? $clog2(SIZE) : 1;
    localparam int unsigned BW    = $clog2(PAYLOAD_BYTES + 1);
    localparam int unsigned PW    = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int unsigned DEPTH = 2 ** (AW + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_OUT
    } t_state;

    t_state                r_state;
    logic                  r_wbank;
    logic [AW-1:0]         r_wcount;
    logic [AW-1:0]         r_scount;
    logic [LIMIT_W-1:0]    r_budget;
    logic [ID_W-1:0]       r_id;
    logic [LIMIT_W-1:0]    r_limit;
    logic [AW-1:0]         r_len;
    logic [MAX_PACKETS-1:0] r_sel;
    logic [PIDX_W-1:0]     r_pkt;
    logic [AW-1:0]         r_base;
    logic [BW-1:0]         r_bi;
    logic                  r_rd_vld;
    logic [PW-1:0]         r_rd_pos;
    logic                  r_rd_zero;
    logic                  r_out_valid;
    logic [PAY_W-1:0]      r_pay;
    logic                  r_ack;

    t_req                  w_req;
    logic                  w_in_acc;
    logic                  w_out_acc;
    logic                  w_cfg_wr;
    logic                  w_room;
    logic                  w_id_ok;
    logic [BYTE_W-1:0]     n_mask;
    logic [AW-1:0]         n_len;
    logic [MAX_PACKETS-1:0] n_sel;
    logic [ID_W-1:0]       w_id_inc;
    logic [ID_W-1:0]       n_id;
    logic [AW-1:0]         w_rd_idx;
    logic                  w_rd_fire;
    logic [BYTE_W-1:0]     w_ram_q;
    logic                  w_last;

    assign w_req     = t_req'(i_req_type);
    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign w_out_acc = r_out_valid && !i_out_stall;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_room    = r_wcount < AW'(SIZE - 1);

    // A request for another message, or one past its budget, sees no data.
    assign n_mask  = (i_requested_bits == '0) ? ALL_PACKETS : i_requested_bits;
    assign w_id_ok = (i_requested_id == '0) || (i_requested_id == {1'b0, r_id});
    assign n_len   = ((r_budget != '0) && w_id_ok) ? r_scount : '0;

    always_comb begin
        for (int p = 0; p < MAX_PACKETS; p++) begin
            n_sel[p] = n_mask[p] && (n_len > AW'(p * PAYLOAD_BYTES));
        end
    end

    // Next id is (id + 1) mod 100 + 1; id + 1 never reaches twice the modulus.
    assign w_id_inc = r_id + 1'b1;
    assign n_id     = ((w_id_inc >= ID_MODULUS) ? (w_id_inc - ID_MODULUS) : w_id_inc) + 1'b1;

    assign w_rd_idx  = r_base + AW'(r_bi);
    assign w_rd_fire = (r_state == S_READ) && (r_bi < BW'(PAYLOAD_BYTES));
    assign w_last    = r_ack || ((r_sel >> 1) == '0);

    prr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (w_in_acc && (w_req == REQ_APPEND) && w_room),
        .i_waddr ({r_wbank, r_wcount}),
        .i_wdata (i_data_byte),
        .i_raddr ({~r_wbank, w_rd_idx}),
        .o_rdata (w_ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wbank     <= 1'b0;
            r_wcount    <= '0;
            r_scount    <= '0;
            r_budget    <= '0;
            r_id        <= ID_RESET;
            r_limit     <= LIMIT_RESET;
            r_out_valid <= 1'b0;
            r_rd_vld    <= 1'b0;
        end else begin
            if (w_cfg_wr && (paddr[2] == REG_LIMIT)) begin
                r_limit <= pwdata[LIMIT_W-1:0];
            end

            r_rd_vld  <= w_rd_fire;
            r_rd_pos  <= PW'(r_bi);
            r_rd_zero <= !(w_rd_idx < r_len);

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        case (w_req)
                            REQ_APPEND: begin
                                if (w_room) begin
                                    r_wcount <= r_wcount + 1'b1;
                                end
                            end
                            REQ_FLUSH: begin
                                r_wbank  <= ~r_wbank;
                                r_scount <= r_wcount;
                                r_wcount <= '0;
                                r_budget <= r_limit;
                                r_id     <= n_id;
                            end
                            REQ_HOST: begin
                                if (r_budget != '0) begin
                                    r_budget <= r_budget - 1'b1;
                                end
                                r_len  <= n_len;
                                r_sel  <= n_sel;
                                r_pkt  <= '0;
                                r_base <= '0;
                                if (n_len == '0) begin
                                    r_ack       <= 1'b1;
                                    r_pay       <= '0;
                                    r_out_valid <= 1'b1;
                                    r_state     <= S_OUT;
                                end else begin
                                    r_ack   <= 1'b0;
                                    r_state <= S_SCAN;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_sel == '0) begin
                        r_state <= S_IDLE;
                    end else if (r_sel[0]) begin
                        r_bi    <= '0;
                        r_pay   <= '0;
                        r_state <= S_READ;
                    end else begin
                        r_sel  <= r_sel >> 1;
                        r_pkt  <= r_pkt + 1'b1;
                        r_base <= r_base + AW'(PAYLOAD_BYTES);
                    end
                end
                S_READ: begin
                    if (w_rd_fire) begin
                        r_bi <= r_bi + 1'b1;
                    end
                    // Bytes past the message length read as zero.
                    if (r_rd_vld) begin
                        r_pay[8*r_rd_pos +: 8] <= r_rd_zero ? '0 : w_ram_q;
                        if (r_rd_pos == PW'(PAYLOAD_BYTES - 1)) begin
                            r_out_valid <= 1'b1;
                            r_state     <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (w_out_acc) begin
                        r_out_valid <= 1'b0;
                        if (w_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_sel   <= r_sel >> 1;
                            r_pkt   <= r_pkt + 1'b1;
                            r_base  <= r_base + AW'(PAYLOAD_BYTES);
                            r_state <= S_SCAN;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_buffer_length = LEN_W'(r_len);
    assign o_packet_index  = r_pkt;
    assign o_message_id    = r_ack ? '0 : r_id;
    assign o_payload       = r_pay;
    assign o_is_ack        = r_ack;
    assign o_last          = w_last;

    assign prdata = (paddr[2] == REG_LIMIT) ? PDATA_W'(r_limit) : '0;
    assign pready = 1'b1;

    // The acknowledgement is always the only word of its answer.
    a_ack_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_ack) |-> o_last)
        else $error("acknowledgement word not marked last");

    // A data word always reports a nonzero message length.
    a_data_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_is_ack) |-> (o_buffer_length != '0))
        else $error("data word with zero length");

    // A host request keeps the input stalled on the following cycle.
    a_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (w_req == REQ_HOST)) |=> o_in_stall)
        else $error("host request did not start a response");

    // The message id stays within one to one hundred.
    a_id_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_id != '0) && (r_id <= ID_MODULUS))
        else $error("message id out of range");

    // The write buffer never holds more than its capacity less one byte.
    a_wcount: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wcount <= AW'(SIZE - 1))
        else $error("write count beyond capacity");

endmodule
